### rtl/rae_pkg.sv
// Shared types and opcode constants for the register ALU execute unit.
`default_nettype none
package rae_pkg;
    localparam logic [3:0] CLS_ARITH = 4'hA;
    localparam logic [3:0] CLS_LOGIC = 4'hB;
    localparam logic [3:0] CLS_FLOW  = 4'hD;
    localparam logic [3:0] CLS_MOVE  = 4'hE;
    localparam logic [3:0] MAX_LABEL_CLS = 4'h9;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;

    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_LT = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_MOD = 4'd3;
    localparam logic [3:0] OP_DIV = 4'd4;
    localparam logic [3:0] OP_AND = 4'd5;
    localparam logic [3:0] OP_OR  = 4'd6;
    localparam logic [3:0] OP_SHL = 4'd7;
    localparam logic [3:0] OP_SHR = 4'd8;
    localparam logic [3:0] OP_XOR = 4'd9;
    localparam logic [3:0] OP_NOT = 4'd10;
    localparam logic [3:0] OP_CMP = 4'd11;
    localparam logic [3:0] OP_PASS = 4'd12;
    localparam logic [3:0] OP_NONE = 4'd13;

    typedef struct packed {
        logic        load;
        logic [3:0]  op;
        logic [3:0]  ra;
        logic [3:0]  rb;
        logic        use_imm;
        logic [3:0]  widx;
        logic        write;
        logic        skip;
        logic        cond;
        logic [2:0]  cond_code;
        logic [1:0]  status;
    } rae_cmd_t;

    typedef struct packed {
        logic done;
    } rae_stat_t;
endpackage
`default_nettype wire

### rtl/rae_ctrl.sv
// Controller that decodes instructions and sequences the datapath.
`default_nettype none
module rae_ctrl
    import rae_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] instruction,
    input  rae_stat_t        stat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rae_cmd_t         cmd
);
    typedef enum logic [1:0] { IDLE, BUSY, HOLD } state_t;
    state_t state_reg;
    logic [3:0] cls, sub, rc, rd;

    assign cls = instruction[15:12];
    assign sub = instruction[11:8];
    assign rc  = instruction[7:4];
    assign rd  = instruction[3:0];
    assign in_ready  = (state_reg == IDLE);
    assign out_valid = (state_reg == HOLD);

    always_comb
    begin
        cmd = '0;
        cmd.op = OP_NONE;
        cmd.load = in_valid && in_ready;
        cmd.ra = rc;
        cmd.rb = rd;
        priority if (cls <= MAX_LABEL_CLS)
        begin
        end
        else if (cls == CLS_ARITH)
        begin
            if (sub <= 4'd4)
            begin
                cmd.op = sub; cmd.write = 1'b1; cmd.widx = rc;
            end
            else if (sub <= 4'd9)
            begin
                cmd.op = sub - 4'd5; cmd.write = 1'b1; cmd.widx = rd;
                cmd.ra = rd; cmd.use_imm = 1'b1; cmd.skip = 1'b1;
            end
            else
                cmd.status = ST_ILLEGAL;
        end
        else if (cls == CLS_LOGIC)
        begin
            if (sub <= 4'd5)
            begin
                cmd.op = sub + OP_AND; cmd.write = 1'b1; cmd.widx = rc;
            end
            else if (sub <= 4'hB)
            begin
                cmd.write = 1'b1; cmd.widx = rd; cmd.ra = rd;
                cmd.use_imm = 1'b1; cmd.skip = 1'b1;
                unique case (sub)
                    4'h6: cmd.op = OP_AND;
                    4'h7: cmd.op = OP_OR;
                    4'h8: cmd.op = OP_SHL;
                    4'h9: cmd.op = OP_SHR;
                    4'hA: cmd.op = OP_NOT;
                    default: cmd.op = OP_XOR;
                endcase
            end
            else
                cmd.status = ST_ILLEGAL;
        end
        else if (cls == CLS_FLOW)
        begin
            if (sub == 4'd1)
                cmd.op = OP_CMP;
            else if (sub == 4'd0 || (sub >= 4'd2 && sub <= 4'd6))
            begin
                cmd.cond = 1'b1; cmd.cond_code = sub[2:0];
            end
            else if (sub != 4'hF)
                cmd.status = ST_ILLEGAL;
        end
        else if (cls == CLS_MOVE)
        begin
            if (sub == 4'd0)
            begin
                cmd.op = OP_PASS; cmd.use_imm = 1'b1; cmd.write = 1'b1;
                cmd.widx = rd; cmd.skip = 1'b1;
            end
            else if (sub == 4'd1)
            begin
                cmd.op = OP_PASS; cmd.write = 1'b1; cmd.widx = rc;
            end
            else if (sub != 4'hA)
                cmd.status = ST_ILLEGAL;
        end
        else
            cmd.status = ST_ILLEGAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE;
        else
        begin
            unique case (state_reg)
                IDLE: if (cmd.load) state_reg <= BUSY;
                BUSY: if (stat.done) state_reg <= HOLD;
                HOLD: if (out_ready) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/rae_datapath.sv
// Datapath with register file, ALU, serial divider and compare flag.
`default_nettype none
module rae_datapath
    import rae_pkg::*;
#(
    parameter int REG_COUNT  = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  rae_cmd_t                cmd,
    input  wire logic signed [31:0] next_word,
    output rae_stat_t               stat,
    output logic [1:0]              status,
    output logic                    dest_written,
    output logic [3:0]              dest_index,
    output logic signed [31:0]      dest_value,
    output logic                    skip_next_word,
    output logic                    jump_taken,
    output logic signed [31:0]      jump_label,
    output logic [1:0]              compare_state
);
    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] rf_reg [REG_COUNT];
    logic [1:0]    flag_reg;
    logic [DW-1:0] a_reg, b_reg, rem_reg, quo_reg;
    logic [3:0]    op_reg;
    logic          busy_reg, neg_q_reg, neg_r_reg, div_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] imm, ra_v, rb_v, res;
    logic [DW:0]   trial;
    logic [4:0]    sh;
    logic          wr_ok;
    logic [DW-1:0] prod;

    assign imm  = DW'(signed'(next_word));
    assign ra_v = (32'(cmd.ra) < REG_COUNT) ? rf_reg[cmd.ra[$clog2(REG_COUNT)-1:0]] : '0;
    assign rb_v = (32'(cmd.rb) < REG_COUNT) ? rf_reg[cmd.rb[$clog2(REG_COUNT)-1:0]] : '0;
    assign sh = b_reg[4:0];
    assign trial = {rem_reg, a_reg[DW-1]} - {1'b0, b_reg};
    assign prod = a_reg * b_reg;
    assign stat.done = busy_reg && !(div_reg && cnt_reg != '0);

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:  res = a_reg + b_reg;
            OP_SUB:  res = a_reg - b_reg;
            OP_MUL:  res = prod;
            OP_MOD:  res = neg_r_reg ? -rem_reg : rem_reg;
            OP_DIV:  res = neg_q_reg ? -quo_reg : quo_reg;
            OP_AND:  res = a_reg & b_reg;
            OP_OR:   res = a_reg | b_reg;
            OP_SHL:  res = (32'(sh) >= DW) ? '0 : a_reg << sh;
            OP_SHR:  res = (32'(sh) >= DW) ? {DW{a_reg[DW-1]}}
                                           : DW'($signed(a_reg) >>> sh);
            OP_XOR:  res = a_reg ^ b_reg;
            OP_NOT:  res = ~b_reg;
            default: res = b_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++) rf_reg[i] <= '0;
            flag_reg <= CMP_EQ;
            busy_reg <= 1'b0;
            div_reg <= 1'b0;
            cnt_reg <= '0;
            compare_state <= CMP_EQ;
        end
        else if (cmd.load)
        begin
            logic [DW-1:0] bv;
            logic dz, tk;
            bv = cmd.use_imm ? imm : rb_v;
            dz = (cmd.op == OP_DIV || cmd.op == OP_MOD) && bv == '0;
            op_reg <= cmd.op;
            busy_reg <= 1'b1;
            neg_q_reg <= ra_v[DW-1] ^ bv[DW-1];
            neg_r_reg <= ra_v[DW-1];
            div_reg <= (cmd.op == OP_DIV || cmd.op == OP_MOD) && !dz;
            cnt_reg <= CW'(DW);
            rem_reg <= '0;
            if (cmd.op == OP_DIV || cmd.op == OP_MOD)
            begin
                a_reg <= ra_v[DW-1] ? -ra_v : ra_v;
                b_reg <= bv[DW-1] ? -bv : bv;
            end
            else
            begin
                a_reg <= ra_v;
                b_reg <= bv;
            end
            wr_ok <= cmd.write && !dz && 32'(cmd.widx) < REG_COUNT;
            dest_index <= cmd.widx;
            status <= dz ? ST_DIVZERO : cmd.status;
            unique case (cmd.cond_code)
                3'd0: tk = 1'b1;
                3'd2: tk = flag_reg == CMP_EQ;
                3'd3: tk = flag_reg == CMP_LT;
                3'd4: tk = flag_reg == CMP_GT;
                3'd5: tk = flag_reg != CMP_GT;
                3'd6: tk = flag_reg != CMP_LT;
                default: tk = 1'b0;
            endcase
            jump_taken <= cmd.cond && tk;
            jump_label <= (cmd.cond && tk) ? next_word : '0;
            skip_next_word <= cmd.skip || (cmd.cond && !tk);
            if (cmd.op == OP_CMP)
            begin
                logic [DW-1:0] x, y;
                logic [1:0] f;
                x = ra_v ^ {1'b1, {(DW-1){1'b0}}};
                y = rb_v ^ {1'b1, {(DW-1){1'b0}}};
                f = (x == y) ? CMP_EQ : (x < y) ? CMP_LT : CMP_GT;
                flag_reg <= f;
                compare_state <= f;
            end
            else
                compare_state <= flag_reg;
        end
        else if (busy_reg && div_reg && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            a_reg <= a_reg << 1;
            if (!trial[DW])
            begin
                rem_reg <= trial[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DW-2:0], a_reg[DW-1]};
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
        else if (busy_reg)
        begin
            busy_reg <= 1'b0;
            dest_written <= wr_ok;
            dest_value <= wr_ok ? 32'(res) : '0;
            if (!wr_ok) dest_index <= '0;
            if (wr_ok) rf_reg[dest_index[$clog2(REG_COUNT)-1:0]] <= res;
        end
    end
endmodule
`default_nettype wire

### rtl/register_alu_execute_unit.sv
// Top level of the register ALU execute unit.
// An accepted beat is registered into the operand registers; the result is then registered onto the outputs,
// after the serial divider has finished for div and mod.
// A new beat is taken once the previous result beat has been taken.
// Reset is asynchronous and active low; it clears the register file, the compare flag and the control state.
`default_nettype none
module register_alu_execute_unit
    import rae_pkg::*;
#(
    parameter int REG_COUNT  = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // instruction[15:0], next_word[47:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata   // status, dest_written, dest_index, dest_value,
                                       // skip_next_word, jump_taken, jump_label,
                                       // compare_state, zero fill
);
    rae_cmd_t  cmd;
    rae_stat_t stat;
    logic [1:0] status, cmp;
    logic dw, sk, jt;
    logic [3:0] di;
    logic signed [31:0] dv, jl;

    rae_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .instruction(s_tdata[15:0]), .stat(stat), .out_valid(m_tvalid),
        .out_ready(m_tready), .cmd(cmd)
    );

    rae_datapath #(.REG_COUNT(REG_COUNT), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .next_word(s_tdata[47:16]),
        .stat(stat), .status(status), .dest_written(dw), .dest_index(di),
        .dest_value(dv), .skip_next_word(sk), .jump_taken(jt), .jump_label(jl),
        .compare_state(cmp)
    );

    assign m_tdata = {5'd0, cmp, jl, jt, sk, dv, di, dw, status};
endmodule
`default_nettype wire

### rtl/rae_checker.sv
// Port-level assertions for the register ALU execute unit.
`default_nettype none
module rae_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata
);
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid) else $error("result too early");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");
    a_jump_skip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[40] && m_tdata[39])) else $error("jump and skip together");
endmodule
bind register_alu_execute_unit rae_checker u_rae_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the register ALU execute unit.
`timescale 1ns / 100ps
module tb;
    import rae_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [3:0] CLS_MEM = 4'hC;
    localparam logic [3:0] CLS_SYS = 4'hF;
    localparam logic [3:0] FLOW_JMP = 4'h0;
    localparam logic [3:0] FLOW_CMP = 4'h1;
    localparam logic [3:0] FLOW_JGE = 4'h6;
    localparam logic [3:0] FLOW_LABEL = 4'hF;
    localparam logic [3:0] MOVE_IMM = 4'h0;
    localparam logic [3:0] MOVE_REG = 4'h1;
    localparam logic [3:0] MOVE_NOP = 4'hA;

    typedef struct packed {
        logic [1:0]  flag;
        logic [31:0] label;
        logic        jump;
        logic        skip;
        logic [31:0] value;
        logic [3:0]  index;
        logic        written;
        logic [1:0]  status;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    logic [31:0] regs [16];
    logic [1:0]  flag;
    outcome_t    pending [$];
    int          errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;

    register_alu_execute_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] shift_word(logic [31:0] a, logic [31:0] b, logic right);
        logic [4:0] sh;
        sh = b[4:0];
        return right ? 32'($signed(a) >>> sh) : (a << sh);
    endfunction

    function automatic logic divide_word(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                         output logic [31:0] r);
        logic [31:0] am;
        logic [31:0] bm;
        logic [31:0] q;
        r = '0;
        if (b == 0)
            return 1'b0;
        am = a[31] ? -a : a;
        bm = b[31] ? -b : b;
        if (op == OP_MOD)
        begin
            q = am % bm;
            r = a[31] ? -q : q;
        end
        else
        begin
            q = am / bm;
            r = (a[31] != b[31]) ? -q : q;
        end
        return 1'b1;
    endfunction

    function automatic logic arith_word(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                        output logic [31:0] r);
        r = '0;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            default: return divide_word(op, a, b, r);
        endcase
        return 1'b1;
    endfunction

    function automatic logic [31:0] logic_word(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        case (op)
            OP_AND: return a & b;
            OP_OR:  return a | b;
            OP_SHL: return shift_word(a, b, 1'b0);
            OP_SHR: return shift_word(a, b, 1'b1);
            OP_XOR: return a ^ b;
            default: return ~b;
        endcase
    endfunction

    function automatic logic [1:0] compare_words(logic [31:0] a, logic [31:0] b);
        if (a == b)
            return CMP_EQ;
        return ($signed(a) < $signed(b)) ? CMP_LT : CMP_GT;
    endfunction

    function automatic outcome_t execute(logic [15:0] inst, logic [31:0] word);
        outcome_t o;
        logic [3:0] cls;
        logic [3:0] sub;
        logic [3:0] rc;
        logic [3:0] rd;
        logic [31:0] v;
        logic take;
        logic cond;
        o = '0;
        cls = inst[15:12];
        sub = inst[11:8];
        rc = inst[7:4];
        rd = inst[3:0];
        v = '0;
        take = 1'b0;
        cond = 1'b0;
        if (cls <= MAX_LABEL_CLS)
        begin
        end
        else if (cls == CLS_ARITH)
        begin
            if (sub <= 4)
            begin
                if (arith_word(sub, regs[rc], regs[rd], v))
                begin
                    o.written = 1'b1;
                    o.index = rc;
                end
                else
                    o.status = ST_DIVZERO;
            end
            else if (sub <= 9)
            begin
                o.skip = 1'b1;
                if (arith_word(sub - 4'd5, regs[rd], word, v))
                begin
                    o.written = 1'b1;
                    o.index = rd;
                end
                else
                    o.status = ST_DIVZERO;
            end
            else
                o.status = ST_ILLEGAL;
        end
        else if (cls == CLS_LOGIC)
        begin
            if (sub <= 5)
            begin
                v = logic_word(sub + OP_AND, regs[rc], regs[rd]);
                o.written = 1'b1;
                o.index = rc;
            end
            else if (sub <= 4'hB)
            begin
                case (sub)
                    4'h6: v = logic_word(OP_AND, regs[rd], word);
                    4'h7: v = logic_word(OP_OR, regs[rd], word);
                    4'h8: v = logic_word(OP_SHL, regs[rd], word);
                    4'h9: v = logic_word(OP_SHR, regs[rd], word);
                    4'hA: v = logic_word(OP_NOT, regs[rd], word);
                    default: v = logic_word(OP_XOR, regs[rd], word);
                endcase
                o.written = 1'b1;
                o.index = rd;
                o.skip = 1'b1;
            end
            else
                o.status = ST_ILLEGAL;
        end
        else if (cls == CLS_FLOW)
        begin
            case (sub)
                FLOW_JMP: begin cond = 1'b1; take = 1'b1; end
                FLOW_CMP: flag = compare_words(regs[rc], regs[rd]);
                4'h2: begin cond = 1'b1; take = (flag == CMP_EQ); end
                4'h3: begin cond = 1'b1; take = (flag == CMP_LT); end
                4'h4: begin cond = 1'b1; take = (flag == CMP_GT); end
                4'h5: begin cond = 1'b1; take = (flag != CMP_GT); end
                FLOW_JGE: begin cond = 1'b1; take = (flag != CMP_LT); end
                FLOW_LABEL: ;
                default: o.status = ST_ILLEGAL;
            endcase
            if (cond)
            begin
                if (take)
                begin
                    o.jump = 1'b1;
                    o.label = word;
                end
                else
                    o.skip = 1'b1;
            end
        end
        else if (cls == CLS_MOVE)
        begin
            if (sub == MOVE_IMM)
            begin
                v = word;
                o.written = 1'b1;
                o.index = rd;
                o.skip = 1'b1;
            end
            else if (sub == MOVE_REG)
            begin
                v = regs[rd];
                o.written = 1'b1;
                o.index = rc;
            end
            else if (sub != MOVE_NOP)
                o.status = ST_ILLEGAL;
        end
        else
            o.status = ST_ILLEGAL;
        if (o.written)
        begin
            regs[o.index] = v;
            o.value = v;
        end
        o.flag = flag;
        return o;
    endfunction

    task automatic issue(logic [15:0] inst, logic [31:0] word);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata <= {word, inst};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending.push_back(execute(inst, word));
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(3) - 32'd1;
            3: return $urandom_range(40);
            4: return -32'($urandom_range(40));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_inst();
        logic [3:0] r1;
        logic [3:0] r2;
        r1 = 4'($urandom);
        r2 = 4'($urandom);
        case ($urandom_range(19))
            0: return 16'($urandom);
            1, 2, 3, 4, 5: return {CLS_ARITH, 4'($urandom_range(9)), r1, r2};
            6, 7, 8, 9: return {CLS_LOGIC, 4'($urandom_range(11)), r1, r2};
            10, 11: return {CLS_FLOW, FLOW_CMP, r1, r2};
            12, 13: return {CLS_FLOW, 4'($urandom_range(6)), r1, r2};
            14, 15, 16: return {CLS_MOVE, MOVE_IMM, r1, r2};
            17: return {CLS_MOVE, MOVE_REG, r1, r2};
            default: return {CLS_FLOW, FLOW_LABEL, r1, r2};
        endcase
    endfunction

    task automatic test_directed();
        issue({CLS_MOVE, MOVE_IMM, 8'h01}, 32'h8000_0000);
        issue({CLS_MOVE, MOVE_IMM, 8'h02}, 32'hFFFF_FFFF);
        issue({CLS_MOVE, MOVE_IMM, 8'h03}, 32'h7FFF_FFFF);
        issue({CLS_ARITH, OP_DIV, 8'h12}, 32'h0);
        issue({CLS_ARITH, OP_MOD, 8'h32}, 32'h0);
        issue({CLS_ARITH, OP_DIV, 8'h34}, 32'h0);
        issue({CLS_ARITH, 4'h9, 8'h03}, 32'h0);
        issue({CLS_ARITH, 4'h8, 8'h03}, 32'hFFFF_FFF9);
        issue({CLS_ARITH, OP_MUL, 8'h33}, 32'h0);
        issue({CLS_LOGIC, 4'h9, 8'h01}, 32'h0000_003F);
        issue({CLS_LOGIC, 4'h8, 8'h02}, 32'h0000_001F);
        issue({CLS_LOGIC, 4'hA, 8'h05}, 32'h1234_5678);
        issue({CLS_FLOW, FLOW_CMP, 8'h13}, 32'h0);
        for (int s = 0; s <= 6; s++)
            issue({CLS_FLOW, 4'(s), 8'h00}, 32'hCAFE_0000 + s);
        issue({CLS_FLOW, 4'h7, 8'h00}, 32'h0);
        issue({CLS_MEM, 12'h123}, 32'h0);
        issue({CLS_SYS, 12'hFFF}, 32'h0);
        issue({CLS_MOVE, 4'h5, 8'h00}, 32'h0);
        issue({CLS_MOVE, MOVE_NOP, 8'h00}, 32'h0);
        issue({CLS_ARITH, 4'hB, 8'h00}, 32'h0);
        issue(16'h9FFF, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_random(int count, int sp, int rp);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        repeat (count) issue(rand_inst(), rand_word());
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
        repeat (30) issue(rand_inst(), rand_word());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        flag = CMP_EQ;
        for (int i = 0; i < 16; i++)
            regs[i] = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(660, 24, 86);
        test_random(660, 86, 24);
        test_random(660, 0, 0);
        test_backpressure();
        if (errors == 0)
            $display("register_alu_execute_unit regression: pass");
        else
            $display("register_alu_execute_unit regression: fail");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
                m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[74:0];
            if (pending.size() == 0)
            begin
                $error("result beat with no instruction pending");
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (got.status !== want.status)
                    $error("status: expected %0d, got %0d", want.status, got.status);
                if (got.written !== want.written)
                    $error("dest_written: expected %0d, got %0d", want.written, got.written);
                if (got.index !== want.index)
                    $error("dest_index: expected %0d, got %0d", want.index, got.index);
                if (got.value !== want.value)
                    $error("dest_value: expected %h, got %h", want.value, got.value);
                if (got.skip !== want.skip)
                    $error("skip_next_word: expected %0d, got %0d", want.skip, got.skip);
                if (got.jump !== want.jump)
                    $error("jump_taken: expected %0d, got %0d", want.jump, got.jump);
                if (got.label !== want.label)
                    $error("jump_label: expected %h, got %h", want.label, got.label);
                if (got.flag !== want.flag)
                    $error("compare_state: expected %0d, got %0d", want.flag, got.flag);
                if (got !== want)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("register_alu_execute_unit regression: fail");
            $finish;
        end
    end

    initial
        idle_cycles = 0;
endmodule
